// File: src/rrfp_pkg.sv
// ----------------------------------------------------------------------------
// rrfp_pkg
// shared types and constants of the reader response frame parser
// ----------------------------------------------------------------------------
package rrfp_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'h7F;
  localparam logic [7:0] CODE_CARD    = 8'h90;
  localparam logic [7:0] CODE_BLOCK   = 8'h91;
  localparam logic [7:0] CODE_BAUD    = 8'hAC;
  localparam logic [7:0] STATUS_OK    = 8'h00;

  localparam int BLOCK_BYTES  = 16;
  localparam int BLOCK_OFFSET = 9;
  localparam int CODE_POS     = 1;
  localparam int STATUS_POS   = 2;

  localparam logic [1:0] EV_OK   = 2'd0;
  localparam logic [1:0] EV_CARD = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RCODE,
    ST_RSTAT,
    ST_DECODE,
    ST_BREAD,
    ST_BOUT
  } state_t;

endpackage

// File: src/rrfp_rx_if.sv
// ----------------------------------------------------------------------------
// rrfp_rx_if
// byte request channel from the reader serial line
// ----------------------------------------------------------------------------
interface rrfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: src/rrfp_res_if.sv
// ----------------------------------------------------------------------------
// rrfp_res_if
// decoded response request channel
// ----------------------------------------------------------------------------
interface rrfp_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] block_byte;
  logic [3:0] byte_index;
  logic       last;

  modport source (output valid, output event_res, output block_byte, output byte_index,
                  output last, input ready);
  modport sink (input valid, input event_res, input block_byte, input byte_index,
                input last, output ready);
endinterface

// File: src/reader_response_frame_parser.sv
// ----------------------------------------------------------------------------
// reader_response_frame_parser
// frame parser for card reader responses with a shared store read port
// ----------------------------------------------------------------------------
// rx carries one response byte per request; res carries decoded events.
// a frame is a 0x7F header, a length byte below 0x7F, and a body whose final
// byte is a checksum that is skipped. body bytes go into a frame store that
// is never cleared between frames; per-entry valid bits make unwritten
// entries read as zero after reset.
// the final byte starts a decode sequencer that reads the store through its
// single registered read port: it reads code, then status, then decodes; a
// known code loads a single event into the output register, an unknown code
// loads nothing. a block response with ok status then reads and outputs its
// 16 results one byte at a time. rx is not ready while the sequencer runs.
// a stalled res channel holds the output register and the sequencer waits.
// reset (rst, synchronous) returns to header search and empties the store.
// ----------------------------------------------------------------------------
module reader_response_frame_parser
  import rrfp_pkg::*;
#(
  parameter int STORE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  rrfp_rx_if.sink     rx,
  rrfp_res_if.source  res
);

  localparam int AW = $clog2(STORE_DEPTH);

  state_t          state, state_next;
  logic            in_frame;
  logic [6:0]      bytes_left;
  logic [6:0]      wpos;
  logic [3:0]      cnt, cnt_next;
  logic [7:0]      code;

  logic [7:0]      mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] filled;
  logic [7:0]      rd_data;
  logic            rd_ok;
  logic [7:0]      rd_eff;

  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            rx_take;
  logic            wr_en;
  logic            slot_free;
  logic            load_out;
  logic [1:0]      ev_new;
  logic [7:0]      byte_new;
  logic [3:0]      idx_new;
  logic            last_new;
  logic            code_load;

  assign rx.ready  = (state == ST_IDLE);
  assign rx_take   = rx.valid && rx.ready;
  assign wr_en     = rx_take && in_frame && (bytes_left > 7'd1) && (32'(wpos) < STORE_DEPTH);
  assign slot_free = !res.valid || res.ready;
  assign rd_eff    = rd_ok ? rd_data : 8'h00;

  // frame tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      bytes_left <= 7'd0;
      wpos       <= 7'd0;
    end else if (rx_take) begin
      if (!in_frame) begin
        if (rx.rx_byte == HEADER_BYTE) begin
          in_frame   <= 1'b1;
          bytes_left <= 7'd0;
          wpos       <= 7'd0;
        end
      end else if (bytes_left == 7'd0) begin
        if (rx.rx_byte < HEADER_BYTE) begin
          bytes_left <= rx.rx_byte[6:0];
        end
      end else if (bytes_left > 7'd1) begin
        bytes_left <= bytes_left - 7'd1;
        if (wpos != 7'h7F) begin
          wpos <= wpos + 7'd1;
        end
      end else begin
        bytes_left <= 7'd0;
        in_frame   <= 1'b0;
      end
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wpos[AW-1:0]] <= rx.rx_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wpos[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= filled[rd_addr];
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 4'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (code_load) begin
      code <= rd_eff;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    rd_en      = 1'b0;
    rd_addr    = AW'(CODE_POS);
    load_out   = 1'b0;
    ev_new     = EV_OK;
    byte_new   = 8'h00;
    idx_new    = 4'd0;
    last_new   = 1'b1;
    code_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (rx_take && in_frame && bytes_left == 7'd1) begin
          state_next = ST_RCODE;
        end
      end
      ST_RCODE: begin
        rd_en      = 1'b1;
        rd_addr    = AW'(CODE_POS);
        state_next = ST_RSTAT;
      end
      ST_RSTAT: begin
        code_load  = 1'b1;
        rd_en      = 1'b1;
        rd_addr    = AW'(STATUS_POS);
        state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (code == CODE_BLOCK && rd_eff == STATUS_OK) begin
          cnt_next   = 4'd0;
          state_next = ST_BREAD;
        end else if (code == CODE_CARD || code == CODE_BLOCK || code == CODE_BAUD) begin
          if (code == CODE_CARD) begin
            ev_new = (rd_eff == STATUS_OK) ? EV_CARD : EV_ERR;
          end else if (code == CODE_BAUD) begin
            ev_new = (rd_eff == STATUS_OK) ? EV_OK : EV_ERR;
          end else begin
            ev_new = EV_ERR;
          end
          if (slot_free) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BREAD: begin
        rd_en      = 1'b1;
        rd_addr    = AW'(BLOCK_OFFSET) + AW'(cnt);
        state_next = ST_BOUT;
      end
      ST_BOUT: begin
        ev_new   = EV_OK;
        byte_new = rd_eff;
        idx_new  = cnt;
        last_new = (cnt == 4'(BLOCK_BYTES - 1));
        if (slot_free) begin
          load_out = 1'b1;
          cnt_next = cnt + 4'd1;
          state_next = last_new ? ST_IDLE : ST_BREAD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.event_res  <= ev_new;
      res.block_byte <= byte_new;
      res.byte_index <= idx_new;
      res.last       <= last_new;
    end
  end

  // checks
  a_idle_len: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> bytes_left == 7'd0)
    else $error("length pending outside a frame");

  a_busy_no_frame: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_frame)
    else $error("decode running inside a frame");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    bytes_left < HEADER_BYTE[6:0])
    else $error("length out of range");

  a_not_last_data: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.last |-> res.event_res == EV_OK)
    else $error("non-final result is not block data");

  a_single_clean: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.event_res != EV_OK |->
      res.last && res.block_byte == 8'h00 && res.byte_index == 4'd0)
    else $error("single event carries data");

endmodule
